### hw/rtl/fha_pkg.sv
package fha_pkg;

    // handle and counter widths
    localparam int unsigned HANDLE_W   = 8;
    localparam int unsigned SLOTS      = 256;
    localparam int unsigned COUNT_W    = 9;

    // capacity in effect: pool size clipped to the handle space
    localparam int unsigned POOL_SIZE  = 256;
    localparam logic [COUNT_W-1:0] CAPACITY =
        COUNT_W'((POOL_SIZE > SLOTS) ? SLOTS : POOL_SIZE);

    // operation codes
    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_TRY     = 2'd1,
        OP_RELEASE = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    // status codes
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_EMPTY       = 2'd1,
        ST_BAD_RELEASE = 2'd2,
        ST_EXHAUSTED   = 2'd3
    } status_t;

endpackage

### hw/rtl/fifo_handle_allocator.sv
// Handle allocator with a first-in first-out list of released handles.
// Input channel (s_valid/s_ready): s_operation is allocate, try allocate or
// release, s_handle_in names the handle to release. Result channel
// (m_valid/m_ready): one item per request, m_handle_out with the granted
// handle (zero otherwise) and m_status.
// Each request runs in an accept step and a decide step: the accept edge
// reads the released-handle memory at the queue head and the in-use memory
// at the named handle; the decide step, once the result register is free,
// writes both memories back and loads the result register. So a new item
// is accepted only after the previous one has been decided and written back.
// The result register decouples the two sides: a new item is accepted while
// a result still waits; only the write-back step waits for the result
// register to drain when the receiver stalls.
// Reset (aresetn low, synchronous) empties the queue, clears the created
// count and clears the per-handle valid flags, so every handle reads as not
// in use at once; no clearing pass is needed.
module fifo_handle_allocator (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_operation,
    input  logic [7:0] s_handle_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_handle_out,
    output logic [1:0] m_status
);

    localparam int unsigned HW = fha_pkg::HANDLE_W;
    localparam int unsigned CW = fha_pkg::COUNT_W;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    // memories
    logic [HW-1:0] queue_mem [fha_pkg::SLOTS];
    logic          map_mem   [fha_pkg::SLOTS];

    // control state
    state_t                   state_reg, state_next;
    logic [HW-1:0]            head_reg, head_next;
    logic [HW-1:0]            tail_reg, tail_next;
    logic [CW-1:0]            qcount_reg, qcount_next;
    logic [CW-1:0]            created_reg, created_next;
    logic [fha_pkg::SLOTS-1:0] map_vld_reg, map_vld_next;

    // request captured at accept, plus registered memory reads
    fha_pkg::op_t  op_reg;
    logic [HW-1:0] hin_reg;
    logic [HW-1:0] qrd_reg;
    logic          map_bit_reg;
    logic          map_vld_rd_reg;

    // result register
    logic          m_valid_reg, m_valid_next;
    logic [HW-1:0] m_handle_reg, m_handle_next;
    fha_pkg::status_t m_status_reg, m_status_next;

    // write-back controls
    logic          map_we;
    logic [HW-1:0] map_waddr;
    logic          map_wdata;
    logic          q_we;

    logic accept;
    logic out_free;
    logic in_use;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign in_use   = map_vld_rd_reg && map_bit_reg;

    assign m_valid      = m_valid_reg;
    assign m_handle_out = m_handle_reg;
    assign m_status     = m_status_reg;

    // decide and write back
    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        qcount_next   = qcount_reg;
        created_next  = created_reg;
        map_vld_next  = map_vld_reg;
        m_valid_next  = m_valid_reg;
        m_handle_next = m_handle_reg;
        m_status_next = m_status_reg;
        map_we        = 1'b0;
        map_waddr     = hin_reg;
        map_wdata     = 1'b0;
        q_we          = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    state_next    = S_IDLE;
                    m_valid_next  = 1'b1;
                    m_handle_next = '0;
                    m_status_next = fha_pkg::ST_OK;
                    unique case (op_reg) inside
                        fha_pkg::OP_ALLOC, fha_pkg::OP_TRY: begin
                            if (qcount_reg != '0) begin
                                // reuse oldest released handle
                                head_next     = head_reg + 1'b1;
                                qcount_next   = qcount_reg - 1'b1;
                                map_we        = 1'b1;
                                map_waddr     = qrd_reg;
                                map_wdata     = 1'b1;
                                m_handle_next = qrd_reg;
                            end else if (op_reg == fha_pkg::OP_TRY) begin
                                m_status_next = fha_pkg::ST_EMPTY;
                            end else if (created_reg < fha_pkg::CAPACITY) begin
                                // create a fresh handle
                                created_next  = created_reg + 1'b1;
                                map_we        = 1'b1;
                                map_waddr     = created_reg[HW-1:0];
                                map_wdata     = 1'b1;
                                m_handle_next = created_reg[HW-1:0];
                            end else begin
                                m_status_next = fha_pkg::ST_EXHAUSTED;
                            end
                        end
                        fha_pkg::OP_RELEASE: begin
                            if (({1'b0, hin_reg} < fha_pkg::CAPACITY) && in_use) begin
                                map_we      = 1'b1;
                                map_waddr   = hin_reg;
                                map_wdata   = 1'b0;
                                q_we        = 1'b1;
                                tail_next   = tail_reg + 1'b1;
                                qcount_next = qcount_reg + 1'b1;
                            end else begin
                                m_status_next = fha_pkg::ST_BAD_RELEASE;
                            end
                        end
                        default: begin
                            m_status_next = fha_pkg::ST_OK;
                        end
                    endcase
                    if (map_we) begin
                        map_vld_next[map_waddr] = 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            qcount_reg   <= '0;
            created_reg  <= '0;
            map_vld_reg  <= '0;
            m_valid_reg  <= 1'b0;
            m_handle_reg <= '0;
            m_status_reg <= fha_pkg::ST_OK;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            qcount_reg   <= qcount_next;
            created_reg  <= created_next;
            map_vld_reg  <= map_vld_next;
            m_valid_reg  <= m_valid_next;
            m_handle_reg <= m_handle_next;
            m_status_reg <= m_status_next;
        end
    end

    // captured request
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg         <= fha_pkg::op_t'(s_operation);
            hin_reg        <= s_handle_in;
            map_vld_rd_reg <= map_vld_reg[s_handle_in];
        end
    end

    // released-handle queue memory
    always_ff @(posedge aclk) begin
        if (q_we) begin
            queue_mem[tail_reg] <= hin_reg;
        end
        if (accept) begin
            qrd_reg <= queue_mem[head_reg];
        end
    end

    // in-use map memory
    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_waddr] <= map_wdata;
        end
        if (accept) begin
            map_bit_reg <= map_mem[s_handle_in];
        end
    end

endmodule
